>>> sv/suv_pkg.sv
// Package for the spherical UV texel coordinate unit.
// Widths, CORDIC arctangent table, shared pipeline types. No dependencies.
package suv_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int COORD_WIDTH_DEF   = 32;
    localparam int FIELD_W  = 32;
    localparam int SIZE_W   = 13;
    localparam int IDX_W    = 12;
    localparam int DW       = 64;    // difference / CORDIC datapath width
    localparam int ZW       = 36;    // angle width, one turn = 2^32
    localparam int NORM_MSB = 57;
    localparam int SH_W     = 6;

    localparam logic [ZW-1:0] HALF_TURN = ZW'(64'h8000_0000);
    localparam logic [31:0]   INV_GAIN  = 32'd2608131496;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;

    function automatic logic [ZW-1:0] atan_turn(input int i);
        logic [31:0] t;
        case (i)
            0:  t = 32'h20000000;
            1:  t = 32'h12E4051E;
            2:  t = 32'h09FB385B;
            3:  t = 32'h051111D4;
            4:  t = 32'h028B0D43;
            5:  t = 32'h0145D7E1;
            6:  t = 32'h00A2F61E;
            7:  t = 32'h00517C55;
            8:  t = 32'h0028BE53;
            9:  t = 32'h00145F2F;
            10: t = 32'h000A2F98;
            11: t = 32'h000517CC;
            12: t = 32'h00028BE6;
            13: t = 32'h000145F3;
            14: t = 32'h0000A2F9;
            15: t = 32'h0000517D;
            16: t = 32'h000028BE;
            17: t = 32'h0000145F;
            18: t = 32'h00000A30;
            19: t = 32'h00000518;
            20: t = 32'h0000028C;
            21: t = 32'h00000146;
            22: t = 32'h000000A3;
            23: t = 32'h00000051;
            24: t = 32'h00000029;
            25: t = 32'h00000014;
            26: t = 32'h0000000A;
            27: t = 32'h00000005;
            28: t = 32'h00000003;
            29: t = 32'h00000001;
            30: t = 32'h00000001;
            default: t = 32'h0;
        endcase
        return ZW'(t);
    endfunction

    // one CORDIC vector carried through a pipeline
    typedef struct packed {
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_cvec;

    // sideband that rides alongside the CORDIC data
    typedef struct packed {
        logic                 degen;
        logic signed [DW-1:0] dy;
        logic signed [ZW-1:0] a1;
    } t_side;

endpackage

>>> sv/suv_if.sv
// Valid/ready stream interfaces for the texel coordinate unit.
// Depends on suv_pkg.
interface suv_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [suv_pkg::FIELD_W-1:0]  centre_x;
    logic signed [suv_pkg::FIELD_W-1:0]  centre_y;
    logic signed [suv_pkg::FIELD_W-1:0]  centre_z;
    logic signed [suv_pkg::FIELD_W-1:0]  hit_x;
    logic signed [suv_pkg::FIELD_W-1:0]  hit_y;
    logic signed [suv_pkg::FIELD_W-1:0]  hit_z;
    modport source (output valid, centre_x, centre_y, centre_z, hit_x, hit_y, hit_z,
                    input ready);
    modport sink   (input valid, centre_x, centre_y, centre_z, hit_x, hit_y, hit_z,
                    output ready);
endinterface

interface suv_out_if;
    logic                              valid;
    logic                              ready;
    logic [suv_pkg::IDX_W-1:0]         tex_column;
    logic [suv_pkg::IDX_W-1:0]         tex_row;
    logic                              degenerate;
    modport source (output valid, tex_column, tex_row, degenerate, input ready);
    modport sink   (input valid, tex_column, tex_row, degenerate, output ready);
endinterface

>>> sv/suv_cordic.sv
// Pipelined CORDIC vectoring unit, one register stage per iteration.
// Depends on suv_pkg; sideband of type t_side travels with each beat.
module suv_cordic #(
    parameter int STAGES = suv_pkg::CORDIC_STAGES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  suv_pkg::t_cvec   i_vec,
    input  suv_pkg::t_side   i_side,
    output logic             o_valid,
    output suv_pkg::t_cvec   o_vec,
    output suv_pkg::t_side   o_side
);
    import suv_pkg::*;

    t_cvec r_vec  [STAGES+1];
    t_side r_side [STAGES+1];
    logic  r_vld  [STAGES+1];
    t_cvec n_pre;

    // quadrant fold into the right half plane
    always_comb begin
        n_pre = i_vec;
        if (i_vec.x < 0) begin
            n_pre.z = (i_vec.y >= 0) ? $signed(HALF_TURN) : -$signed(HALF_TURN);
            n_pre.x = -i_vec.x;
            n_pre.y = -i_vec.y;
        end
        if (i_vec.x == 0 && i_vec.y == 0) n_pre = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
        if (i_en) begin
            r_vec[0]  <= n_pre;
            r_side[0] <= i_side;
        end
    end

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        t_cvec n_v;
        logic  zero;
        always_comb begin
            n_v  = r_vec[g];
            zero = (r_vec[g].x == 0) && (r_vec[g].y == 0);
            if (r_vec[g].y >= 0) begin
                n_v.x = r_vec[g].x + (r_vec[g].y >>> g);
                n_v.y = r_vec[g].y - (r_vec[g].x >>> g);
                n_v.z = r_vec[g].z + $signed(atan_turn(g));
            end else begin
                n_v.x = r_vec[g].x - (r_vec[g].y >>> g);
                n_v.y = r_vec[g].y + (r_vec[g].x >>> g);
                n_v.z = r_vec[g].z - $signed(atan_turn(g));
            end
            if (zero) n_v = '0;
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[g+1] <= r_vld[g];
            end
            if (i_en) begin
                r_vec[g+1]  <= n_v;
                r_side[g+1] <= r_side[g];
            end
        end
    end

    assign o_valid = r_vld[STAGES];
    assign o_vec   = r_vec[STAGES];
    assign o_side  = r_side[STAGES];
endmodule

>>> sv/spherical_uv_texel_coord_unit.sv
// Top level of the spherical UV texel coordinate unit.
// Depends on suv_pkg, suv_if and suv_cordic.
//
//  channel   dir  handshake         payload
//  s_in      in   valid/ready       centre_xyz, hit_xyz (Q16.16)
//  m_out     out  valid/ready       tex_column, tex_row, degenerate
//  apb       in   psel/penable      tex_width (0x0), tex_height (0x4)
//
// One beat enters per cycle while the output is not stalled. The pipeline is
// made of the four normalize stages, the two CORDIC pipelines (one stage per
// iteration plus an entry register), the radius multiply and the output stages.
// Synchronous active-low reset clears the valid bits and sets both size
// registers to 256.
// A stall at the output freezes the whole pipeline (global enable), so no
// beat is dropped or repeated; the output register holds while stalled.
module spherical_uv_texel_coord_unit #(
    parameter int CORDIC_STAGES = suv_pkg::CORDIC_STAGES_DEF,
    parameter int COORD_WIDTH   = suv_pkg::COORD_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    suv_in_if.sink      s_in,
    suv_out_if.source   m_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import suv_pkg::*;

    localparam int CW = (COORD_WIDTH > FIELD_W) ? FIELD_W : COORD_WIDTH;

    // ---- configuration registers
    logic [SIZE_W-1:0] r_width, r_height;
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= SIZE_W'(256);
            r_height <= SIZE_W'(256);
        end else if (psel && penable && pwrite) begin
            case (paddr[2:2])
                REG_WIDTH[0]:  r_width  <= pwdata[SIZE_W-1:0];
                REG_HEIGHT[0]: r_height <= pwdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end
    always_comb begin
        case (paddr[2:2])
            REG_WIDTH[0]:  prdata = 32'(r_width);
            default:       prdata = 32'(r_height);
        endcase
    end

    // global enable: advance unless output holds an untaken beat
    logic en;
    logic r_ovld;
    assign en = !r_ovld || m_out.ready;
    assign s_in.ready = en;

    // ---- stage 1: differences
    function automatic logic signed [DW-1:0] sx(input logic [FIELD_W-1:0] v);
        return DW'($signed(v[CW-1:0]));
    endfunction

    logic                 r1_v;
    logic signed [DW-1:0] r1_dx, r1_dy, r1_dz;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else if (en)  r1_v <= s_in.valid;
        if (en) begin
            r1_dx <= sx(s_in.centre_x) - sx(s_in.hit_x);
            r1_dy <= sx(s_in.centre_y) - sx(s_in.hit_y);
            r1_dz <= sx(s_in.centre_z) - sx(s_in.hit_z);
        end
    end

    // ---- stage 2: magnitudes max, or-reduce
    function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
        return v[DW-1] ? DW'(-v) : DW'(v);
    endfunction
    logic                 r2_v, r2_degen;
    logic [DW-1:0]        r2_m;
    logic signed [DW-1:0] r2_dx, r2_dy, r2_dz;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else if (en)  r2_v <= r1_v;
        if (en) begin
            r2_m     <= mag(r1_dx) | mag(r1_dy) | mag(r1_dz);
            r2_degen <= (r1_dx == 0) && (r1_dy == 0) && (r1_dz == 0);
            r2_dx <= r1_dx; r2_dy <= r1_dy; r2_dz <= r1_dz;
        end
    end

    // ---- stage 3: shift count (leading one of OR equals that of the max)
    logic [SH_W-1:0] n_k;
    always_comb begin
        n_k = '0;
        for (int b = 0; b <= NORM_MSB; b++) begin
            if (r2_m[b]) n_k = SH_W'(NORM_MSB - b);
        end
    end
    logic                 r3_v, r3_degen;
    logic [SH_W-1:0]      r3_k;
    logic signed [DW-1:0] r3_dx, r3_dy, r3_dz;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else if (en)  r3_v <= r2_v;
        if (en) begin
            r3_k <= n_k; r3_degen <= r2_degen;
            r3_dx <= r2_dx; r3_dy <= r2_dy; r3_dz <= r2_dz;
        end
    end

    // ---- stage 4: normalize
    logic                 r4_v, r4_degen;
    logic signed [DW-1:0] r4_dx, r4_dy, r4_dz;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else if (en)  r4_v <= r3_v;
        if (en) begin
            r4_degen <= r3_degen;
            r4_dx <= r3_dx <<< r3_k; r4_dy <= r3_dy <<< r3_k; r4_dz <= r3_dz <<< r3_k;
        end
    end

    // ---- first CORDIC: atan2(dz, dx) and gain*radius
    t_cvec c1_in, c1_out;
    t_side s1_in, s1_out;
    logic  c1_v;
    assign c1_in = '{x: r4_dx, y: r4_dz, z: '0};
    assign s1_in = '{degen: r4_degen, dy: r4_dy, a1: '0};
    suv_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_azim (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(r4_v), .i_vec(c1_in), .i_side(s1_in),
        .o_valid(c1_v), .o_vec(c1_out), .o_side(s1_out)
    );

    // ---- radius: (len>>30) * INV_GAIN >> 2
    logic [33:0] n_len;
    assign n_len = c1_out.x[DW-1] ? 34'd0 : c1_out.x[63:30];
    logic        r5_v;
    logic [33:0] r5_len;
    t_side       r5_side;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_v <= 1'b0;
        else if (en)  r5_v <= c1_v;
        if (en) begin
            r5_len  <= n_len;
            r5_side <= '{degen: s1_out.degen, dy: s1_out.dy, a1: c1_out.z};
        end
    end
    // 34x32 product split in two partial products over two stages
    logic        r6_v;
    logic [65:0] r6_lo;
    logic [33:0] r6_hi;
    t_side       r6_side;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r6_v <= 1'b0;
        else if (en)  r6_v <= r5_v;
        if (en) begin
            r6_lo   <= 66'(r5_len[16:0]) * 66'(INV_GAIN);
            r6_hi   <= r5_len[33:17];
            r6_side <= r5_side;
        end
    end
    logic        r7_v;
    logic [65:0] r7_prod;
    t_side       r7_side;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r7_v <= 1'b0;
        else if (en)  r7_v <= r6_v;
        if (en) begin
            r7_prod <= r6_lo + ((66'(r6_hi[16:0]) * 66'(INV_GAIN)) << 17);
            r7_side <= r6_side;
        end
    end

    // ---- second CORDIC: atan2(dy, r)
    t_cvec c2_in, c2_out;
    t_side s2_out;
    logic  c2_v;
    assign c2_in = '{x: $signed(r7_prod[65:2]), y: r7_side.dy, z: '0};
    suv_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_elev (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(r7_v), .i_vec(c2_in), .i_side(r7_side),
        .o_valid(c2_v), .o_vec(c2_out), .o_side(s2_out)
    );

    // ---- fractions, clamped to [0, 2^32]
    function automatic logic [32:0] clampf(input logic signed [ZW+1:0] f);
        if (f < 0) return 33'd0;
        if (f > $signed((ZW+2)'(64'h1_0000_0000))) return 33'h1_0000_0000;
        return f[32:0];
    endfunction
    function automatic logic [SIZE_W-1:0] effsz(input logic [SIZE_W-1:0] r);
        if (r == 0) return SIZE_W'(1);
        if (r > SIZE_W'(4096)) return SIZE_W'(4096);
        return r;
    endfunction

    logic        r8_v, r8_degen;
    logic [32:0] r8_fu, r8_fv;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r8_v <= 1'b0;
        else if (en)  r8_v <= c2_v;
        if (en) begin
            r8_degen <= s2_out.degen;
            r8_fu <= clampf((ZW+2)'($signed(HALF_TURN)) + (ZW+2)'(s2_out.a1));
            r8_fv <= clampf((ZW+2)'($signed(HALF_TURN)) - ((ZW+2)'(c2_out.z) <<< 1));
        end
    end

    // ---- scale by size
    logic        r9_v, r9_degen;
    logic [45:0] r9_pu, r9_pv;
    logic [SIZE_W-1:0] r9_w, r9_h;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r9_v <= 1'b0;
        else if (en)  r9_v <= r8_v;
        if (en) begin
            r9_degen <= r8_degen;
            r9_w  <= effsz(r_width);
            r9_h  <= effsz(r_height);
            r9_pu <= 46'(effsz(r_width))  * 46'(r8_fu);
            r9_pv <= 46'(effsz(r_height)) * 46'(r8_fv);
        end
    end

    // ---- index clamp, output register
    logic [13:0] iu, iv;
    assign iu = r9_pu[45:32];
    assign iv = r9_pv[45:32];
    logic [IDX_W-1:0] r_col, r_row;
    logic             r_deg;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovld <= 1'b0;
        else if (en)  r_ovld <= r9_v;
        if (en) begin
            r_deg <= r9_degen;
            if (r9_degen) begin
                r_col <= '0;
                r_row <= '0;
            end else begin
                r_col <= (iu >= 14'(r9_w)) ? IDX_W'(r9_w - 1'b1) : iu[IDX_W-1:0];
                r_row <= (iv >= 14'(r9_h)) ? IDX_W'(r9_h - 1'b1) : iv[IDX_W-1:0];
            end
        end
    end

    assign m_out.valid      = r_ovld;
    assign m_out.tex_column = r_col;
    assign m_out.tex_row    = r_row;
    assign m_out.degenerate = r_deg;
endmodule

>>> sv/suv_checker.sv
// Port-level checker for the texel coordinate unit, bound to the top level.
// Depends on the top level's port list only.
module suv_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [11:0] col,
    input logic [11:0] row,
    input logic        degen,
    input logic        pready
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(col) && $stable(row))
        else $error("output beat changed while stalled");
    a_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && degen |-> col == 12'd0 && row == 12'd0)
        else $error("degenerate beat with nonzero coordinates");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");
    // input held off only behind a waiting output beat
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output back-pressure");
    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready low");
endmodule

bind spherical_uv_texel_coord_unit suv_checker u_suv_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(s_in.valid), .in_ready(s_in.ready),
    .out_valid(m_out.valid), .out_ready(m_out.ready),
    .col(m_out.tex_column), .row(m_out.tex_row), .degen(m_out.degenerate),
    .pready(pready)
);
